// File: rtl/rv64d_pkg.sv
// ----------------------------------------------------------------------------
// Shared types and constants for the instruction decoder with label table.
// Opcodes, mnemonic codes, state machine encoding and the decode result type.
// ----------------------------------------------------------------------------
package rv64d_pkg;

   localparam int unsigned LabelDepthDefault = 1024;
   localparam int unsigned IndexWidth        = 20;
   localparam int unsigned TargetWidth       = 22;
   localparam int unsigned LabelWidth        = 11;
   localparam int unsigned ImmWidth          = 21;
   localparam int unsigned MnemWidth         = 6;

   localparam logic [6:0] OpReg    = 7'd51;
   localparam logic [6:0] OpImm    = 7'd19;
   localparam logic [6:0] OpLoad   = 7'd3;
   localparam logic [6:0] OpJalr   = 7'd103;
   localparam logic [6:0] OpStore  = 7'd35;
   localparam logic [6:0] OpBranch = 7'd99;
   localparam logic [6:0] OpJal    = 7'd111;
   localparam logic [6:0] OpLui    = 7'd55;

   localparam logic [6:0] Funct7Zero = 7'd0;
   localparam logic [6:0] Funct7Alt  = 7'd32;
   localparam logic [5:0] Funct6Zero = 6'd0;
   localparam logic [5:0] Funct6Alt  = 6'd16;

   localparam logic [MnemWidth-1:0] MnSub   = 6'd1;
   localparam logic [MnemWidth-1:0] MnSra   = 6'd7;
   localparam logic [MnemWidth-1:0] MnSlli  = 6'd14;
   localparam logic [MnemWidth-1:0] MnSrli  = 6'd15;
   localparam logic [MnemWidth-1:0] MnSrai  = 6'd16;
   localparam logic [MnemWidth-1:0] MnLoad  = 6'd19;
   localparam logic [MnemWidth-1:0] MnJalr  = 6'd26;
   localparam logic [MnemWidth-1:0] MnStore = 6'd27;
   localparam logic [MnemWidth-1:0] MnJal   = 6'd37;
   localparam logic [MnemWidth-1:0] MnLui   = 6'd38;
   localparam logic [MnemWidth-1:0] MnNone  = 6'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HERE,
      ST_TGT,
      ST_APPEND,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [MnemWidth-1:0]  mnemonic;
      logic                  known;
      logic                  jump;
      logic [4:0]            dest_reg;
      logic [4:0]            src1_reg;
      logic [4:0]            src2_reg;
      logic [ImmWidth-1:0]   immediate;
   } dec_type;

   function automatic logic [MnemWidth-1:0] rmap(input logic [2:0] f3);
      logic [MnemWidth-1:0] r;
      case (f3)
         3'd0: r = 6'd0;
         3'd1: r = 6'd5;
         3'd2: r = 6'd8;
         3'd3: r = 6'd9;
         3'd4: r = 6'd2;
         3'd5: r = 6'd6;
         3'd6: r = 6'd3;
         3'd7: r = 6'd4;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   function automatic logic [MnemWidth-1:0] imap(input logic [2:0] f3);
      logic [MnemWidth-1:0] r;
      case (f3)
         3'd0: r = 6'd10;
         3'd2: r = 6'd17;
         3'd3: r = 6'd18;
         3'd4: r = 6'd11;
         3'd6: r = 6'd12;
         3'd7: r = 6'd13;
         default: r = 6'd10;
      endcase
      return r;
   endfunction

   function automatic logic [MnemWidth-1:0] bmap(input logic [2:0] f3);
      logic [MnemWidth-1:0] r;
      case (f3)
         3'd0: r = 6'd31;
         3'd1: r = 6'd32;
         3'd4: r = 6'd33;
         3'd5: r = 6'd34;
         3'd6: r = 6'd35;
         3'd7: r = 6'd36;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/rv64i_decode_with_label_table.sv
// ----------------------------------------------------------------------------
// Instruction decoder with label table
// Decodes one instruction per transfer and tracks branch and jal targets.
// ----------------------------------------------------------------------------
// One shared compare unit walks the label table through its single memory
// port once for the current index and, for a branch or jal, once more for
// the target, followed by an append step if the target was not found. A
// match ends a walk early. The result waits in an output register, and the
// block holds in its last step while the previous result has not yet been
// taken.
module rv64i_decode_with_label_table
   import rv64d_pkg::*;
#(
   parameter int unsigned LABEL_DEPTH = LabelDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // instr_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // mnemonic[5:0], known[6], dest_reg[11:7], src1_reg[16:12], src2_reg[21:17],
   // immediate[42:22], label_here[53:43], target_label[64:54], table_full[65]
   output logic [71:0] rsp_tdata
);

   localparam int unsigned AW = $clog2(LABEL_DEPTH);
   localparam int unsigned CW = AW + 1;

   state_type              state_ff, state_in;
   logic [31:0]            word_ff, word_in;
   logic [IndexWidth-1:0]  index_ff, index_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          ptr_ff, ptr_in;
   logic                   rd_ok_ff, rd_ok_in;
   logic [TargetWidth-1:0] key_ff, key_in;
   logic [LabelWidth-1:0]  here_ff, here_in;
   logic [LabelWidth-1:0]  tlab_ff, tlab_in;
   logic                   full_ff, full_in;
   logic                   valid_ff, valid_in;
   logic [71:0]            data_ff, data_in;

   dec_type                dec;
   logic                   wr_en;
   logic [AW-1:0]          addr;
   logic [TargetWidth-1:0] rd_data;
   logic                   hit;
   logic [CW-1:0]          hit_label;
   logic signed [ImmWidth-1:0] imm_s;
   logic signed [ImmWidth-1:0] quarter;
   logic [TargetWidth-1:0] target;

   rv64d_decode u_decode (
      .instr_word (word_ff),
      .dec        (dec)
   );

   rv64d_table #(
      .LABEL_DEPTH (LABEL_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (addr),
      .wr_data (key_ff),
      .rd_data (rd_data)
   );

   assign imm_s   = dec.immediate;
   assign quarter = (imm_s >>> 2) + ((imm_s[ImmWidth-1] && imm_s[1:0] != 2'd0) ?
                    ImmWidth'(1) : ImmWidth'(0));
   assign target  = TargetWidth'({2'b00, index_ff}) +
                    {{(TargetWidth-ImmWidth){quarter[ImmWidth-1]}}, quarter};

   // The shared compare unit: previous read address is ptr_ff - 1.
   assign hit       = rd_ok_ff && (rd_data == key_ff);
   assign hit_label = ptr_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   always_comb begin
      state_in = state_ff;
      word_in  = word_ff;
      index_in = index_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      rd_ok_in = 1'b0;
      key_in   = key_ff;
      here_in  = here_ff;
      tlab_in  = tlab_ff;
      full_in  = full_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      wr_en    = 1'b0;
      addr     = ptr_ff[AW-1:0];
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               word_in  = req_tdata;
               key_in   = {2'b00, index_ff};
               ptr_in   = '0;
               here_in  = '0;
               tlab_in  = '0;
               full_in  = 1'b0;
               state_in = ST_HERE;
            end
         end
         ST_HERE, ST_TGT: begin
            if (hit) begin
               if (state_ff == ST_HERE) begin
                  here_in = LabelWidth'(hit_label);
               end else begin
                  tlab_in = LabelWidth'(hit_label);
               end
            end
            if (hit || (ptr_ff == count_ff && !rd_ok_ff) ||
                (ptr_ff == count_ff && rd_ok_ff && !hit)) begin
               if (!hit && ptr_ff != count_ff) begin
                  rd_ok_in = 1'b1;
                  ptr_in   = ptr_ff + CW'(1);
               end else if (state_ff == ST_HERE && dec.jump) begin
                  key_in   = target;
                  ptr_in   = '0;
                  state_in = ST_TGT;
               end else if (state_ff == ST_TGT && !hit) begin
                  state_in = ST_APPEND;
               end else begin
                  state_in = ST_OUT;
               end
            end else begin
               rd_ok_in = 1'b1;
               ptr_in   = ptr_ff + CW'(1);
            end
         end
         ST_APPEND: begin
            addr = count_ff[AW-1:0];
            if (count_ff < CW'(LABEL_DEPTH)) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               tlab_in  = LabelWidth'(count_ff + CW'(1));
            end else begin
               full_in = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!valid_ff || rsp_tready) begin
               valid_in = 1'b1;
               data_in  = {6'd0, full_ff, tlab_ff, here_ff, dec.immediate,
                           dec.src2_reg, dec.src1_reg, dec.dest_reg, dec.known,
                           dec.mnemonic};
               index_in = index_ff + IndexWidth'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         index_ff <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         index_ff <= index_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         rd_ok_ff <= rd_ok_in;
      end
      word_ff <= word_in;
      ptr_ff  <= ptr_in;
      key_ff  <= key_in;
      here_ff <= here_in;
      tlab_ff <= tlab_in;
      full_ff <= full_in;
      data_ff <= data_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(LABEL_DEPTH))
      else $error("label count beyond table depth");
   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPEND && count_ff < CW'(LABEL_DEPTH)) |=> !full_ff)
      else $error("table full flagged with room left");
   a_count_grows_by_one: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> count_ff == $past(count_ff) + CW'(1))
      else $error("label count jumped");
`endif

endmodule

// File: rtl/rv64d_decode.sv
// ----------------------------------------------------------------------------
// Instruction field decoder
// Turns one instruction word into a mnemonic code, registers and immediate.
// ----------------------------------------------------------------------------
module rv64d_decode
   import rv64d_pkg::*;
(
   input  logic [31:0] instr_word,
   output dec_type     dec
);

   logic [6:0] op;
   logic [2:0] f3;
   logic [6:0] f7;
   logic [5:0] f6;
   logic [ImmWidth-1:0] immi;

   assign op   = instr_word[6:0];
   assign f3   = instr_word[14:12];
   assign f7   = instr_word[31:25];
   assign f6   = instr_word[31:26];
   assign immi = {{(ImmWidth-12){instr_word[31]}}, instr_word[31:20]};

   always_comb begin
      dec = '0;
      case (op)
         OpReg: begin
            if (f7 == Funct7Zero) begin
               dec.mnemonic = rmap(f3);
               dec.known    = 1'b1;
            end else if (f7 == Funct7Alt && f3 == 3'd0) begin
               dec.mnemonic = MnSub;
               dec.known    = 1'b1;
            end else if (f7 == Funct7Alt && f3 == 3'd5) begin
               dec.mnemonic = MnSra;
               dec.known    = 1'b1;
            end
            if (dec.known) begin
               dec.dest_reg = instr_word[11:7];
               dec.src1_reg = instr_word[19:15];
               dec.src2_reg = instr_word[24:20];
            end
         end
         OpImm: begin
            if (f3 == 3'd1 || f3 == 3'd5) begin
               // The shift amount is reported even when the upper bits do not match.
               dec.immediate = {{(ImmWidth-6){1'b0}}, instr_word[25:20]};
               if (f3 == 3'd1 && f6 == Funct6Zero) begin
                  dec.mnemonic = MnSlli;
                  dec.known    = 1'b1;
               end else if (f3 == 3'd5 && f6 == Funct6Zero) begin
                  dec.mnemonic = MnSrli;
                  dec.known    = 1'b1;
               end else if (f3 == 3'd5 && f6 == Funct6Alt) begin
                  dec.mnemonic = MnSrai;
                  dec.known    = 1'b1;
               end
            end else begin
               dec.mnemonic  = imap(f3);
               dec.known     = 1'b1;
               dec.immediate = immi;
            end
            if (dec.known) begin
               dec.dest_reg = instr_word[11:7];
               dec.src1_reg = instr_word[19:15];
            end
         end
         OpLoad: begin
            if (f3 != 3'd7) begin
               dec.mnemonic  = MnLoad + {3'd0, f3};
               dec.known     = 1'b1;
               dec.dest_reg  = instr_word[11:7];
               dec.src1_reg  = instr_word[19:15];
               dec.immediate = immi;
            end
         end
         OpJalr: begin
            if (f3 == 3'd0) begin
               dec.mnemonic  = MnJalr;
               dec.known     = 1'b1;
               dec.dest_reg  = instr_word[11:7];
               dec.src1_reg  = instr_word[19:15];
               dec.immediate = immi;
            end
         end
         OpStore: begin
            if (!f3[2]) begin
               dec.mnemonic  = MnStore + {3'd0, f3};
               dec.known     = 1'b1;
               dec.src1_reg  = instr_word[19:15];
               dec.src2_reg  = instr_word[24:20];
               dec.immediate = {{(ImmWidth-12){instr_word[31]}}, instr_word[31:25],
                                instr_word[11:7]};
            end
         end
         OpBranch: begin
            if (f3 != 3'd2 && f3 != 3'd3) begin
               dec.mnemonic  = bmap(f3);
               dec.known     = 1'b1;
               dec.jump      = 1'b1;
               dec.src1_reg  = instr_word[19:15];
               dec.src2_reg  = instr_word[24:20];
               dec.immediate = {{(ImmWidth-13){instr_word[31]}}, instr_word[31],
                                instr_word[7], instr_word[30:25], instr_word[11:8], 1'b0};
            end
         end
         OpJal: begin
            dec.mnemonic  = MnJal;
            dec.known     = 1'b1;
            dec.jump      = 1'b1;
            dec.dest_reg  = instr_word[11:7];
            dec.immediate = {instr_word[31], instr_word[19:12], instr_word[20],
                             instr_word[30:21], 1'b0};
         end
         OpLui: begin
            dec.mnemonic  = MnLui;
            dec.known     = 1'b1;
            dec.dest_reg  = instr_word[11:7];
            dec.immediate = {instr_word[31], instr_word[31:12]};
         end
         default: begin
            dec = '0;
         end
      endcase
   end

endmodule

// File: rtl/rv64d_table.sv
// ----------------------------------------------------------------------------
// Label table store
// Single-port memory of label targets with a registered read port.
// ----------------------------------------------------------------------------
module rv64d_table
   import rv64d_pkg::*;
#(
   parameter int unsigned LABEL_DEPTH = LabelDepthDefault
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(LABEL_DEPTH)-1:0] addr,
   input  logic [TargetWidth-1:0]         wr_data,
   output logic [TargetWidth-1:0]         rd_data
);

   logic [TargetWidth-1:0] mem [LABEL_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule
